FILE: hdl/hsc_pkg.sv
// Package for the chained hash set: sizes, operation codes, bucket row
// layout and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package hsc_pkg;

   localparam int NUM_BUCKETS      = 256;
   localparam int SLOTS_PER_BUCKET = 4;

   localparam int VAL_W  = 32;
   localparam int FUNC_W = 2;
   localparam int CFG_W  = 9;
   localparam int REM_W  = CFG_W + 1;
   localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int SLT_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int BIT_W  = $clog2(VAL_W);

   localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = CFG_W'(256);

   typedef enum logic [FUNC_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   // One bucket: its valid bits and its slot values, read and written whole.
   typedef struct packed {
      logic [SLOTS_PER_BUCKET-1:0]            vld;
      logic [SLOTS_PER_BUCKET-1:0][VAL_W-1:0] vals;
   } row_type;

   typedef struct packed {
      logic load;      // capture the request transaction
      logic div_step;  // one restoring step of value mod bucket count
      logic rd;        // read the bucket row
      logic wr;        // resolve the operation, update the row, load the result
      logic clr;       // clear one row of the store
   } hsc_cmd_type;

   typedef struct packed {
      logic div_last;
      logic clr_last;
   } hsc_sts_type;

endpackage

`default_nettype wire

FILE: hdl/hsc_dp.sv
// Datapath of the chained hash set: bucket-count register, serial modulo
// unit, bucket row store with its clearing counter, and result register.
// Depends on hsc_pkg.
`default_nettype none

module hsc_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire hsc_pkg::hsc_cmd_type       cmd,
   output hsc_pkg::hsc_sts_type            sts,
   input  wire logic [hsc_pkg::FUNC_W-1:0] req_func,
   input  wire logic [hsc_pkg::VAL_W-1:0]  req_value,
   input  wire logic                       csr_we,
   input  wire logic [hsc_pkg::CFG_W-1:0]  csr_wdata,
   output logic [2:0]                      rsp_bits
);
   import hsc_pkg::*;

   logic [CFG_W-1:0]  bcount_ff;
   logic [REM_W-1:0]  eff_n;
   logic [FUNC_W-1:0] op_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [VAL_W-1:0]  shf_ff, shf_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  trial;
   logic [BIT_W-1:0]  bitcnt_ff;
   logic [BKT_W-1:0]  clr_addr_ff;
   logic [BKT_W-1:0]  bucket;
   row_type           mem [NUM_BUCKETS];
   row_type           row_ff;
   row_type           wrow;
   logic              fnd, has_free, hit, chg, full;
   logic [SLT_W-1:0]  fidx, fridx;
   logic [2:0]        rsp_ff;

   // Bucket count register; zero acts as one, large counts saturate.
   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff <= BUCKET_COUNT_RESET;
      end else if (csr_we) begin
         bcount_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (bcount_ff == '0) begin
         eff_n = REM_W'(1);
      end else if (int'(bcount_ff) > NUM_BUCKETS) begin
         eff_n = REM_W'(NUM_BUCKETS);
      end else begin
         eff_n = REM_W'(bcount_ff);
      end
   end

   // Restoring modulo, one dividend bit per step, most significant first.
   always_comb begin
      trial  = {rem_ff[REM_W-2:0], shf_ff[VAL_W-1]};
      rem_in = (trial >= eff_n) ? (trial - eff_n) : trial;
      shf_in = {shf_ff[VAL_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_func;
         val_ff    <= req_value;
         shf_ff    <= req_value;
         rem_ff    <= '0;
         bitcnt_ff <= '0;
      end else if (cmd.div_step) begin
         shf_ff    <= shf_in;
         rem_ff    <= rem_in;
         bitcnt_ff <= bitcnt_ff + 1'b1;
      end
   end

   assign bucket = BKT_W'(rem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign sts.div_last = (bitcnt_ff == BIT_W'(VAL_W - 1));
   assign sts.clr_last = (clr_addr_ff == BKT_W'(NUM_BUCKETS - 1));

   // Scan the row; descending order lets the lowest slot win.
   always_comb begin
      fnd      = 1'b0;
      has_free = 1'b0;
      fidx     = '0;
      fridx    = '0;
      for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
         if (row_ff.vld[i] && (row_ff.vals[i] == val_ff)) begin
            fnd  = 1'b1;
            fidx = SLT_W'(i);
         end
         if (!row_ff.vld[i]) begin
            has_free = 1'b1;
            fridx    = SLT_W'(i);
         end
      end
   end

   always_comb begin
      wrow = row_ff;
      hit  = 1'b0;
      chg  = 1'b0;
      full = 1'b0;
      case (op_ff)
         OP_INSERT: begin
            if (fnd) begin
               hit = 1'b1;
            end else if (has_free) begin
               chg               = 1'b1;
               wrow.vld[fridx]   = 1'b1;
               wrow.vals[fridx]  = val_ff;
            end else begin
               full = 1'b1;
            end
         end
         OP_SEARCH: begin
            hit = fnd;
         end
         OP_REMOVE: begin
            if (fnd) begin
               hit            = 1'b1;
               chg            = 1'b1;
               wrow.vld[fidx] = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Row store: clearing pass after reset, read-modify-write per operation.
   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.wr && chg) begin
         mem[bucket] <= wrow;
      end
      if (cmd.rd) begin
         row_ff <= mem[bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         rsp_ff <= {full, chg, hit};
      end
   end

   assign rsp_bits = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/hsc_ctrl.sv
// Controller of the chained hash set: sequences clear, modulo, row read and
// update, and owns the request and response handshakes.
// Depends on hsc_pkg.
`default_nettype none

module hsc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output hsc_pkg::hsc_cmd_type      cmd,
   input  wire hsc_pkg::hsc_sts_type sts
);
   import hsc_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               cmd.wr       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hdl/hash_set_chained.sv
// Top level of the chained hash set: joins the controller and the datapath.
// Depends on hsc_pkg, hsc_ctrl and hsc_dp.
`default_nettype none

//  channel   direction  handshake                payload
//  req_      in         req_tvalid / req_tready  tdata: value; tuser: func
//  rsp_      out        rsp_tvalid / rsp_tready  tdata: hit, changed, full_res
//  csr_      in         csr_valid / csr_ready    csr_data: bucket_count
//
//  One item goes from acceptance to result through capture, the bit-serial modulo
//  (one dividend bit per cycle), the row read, and the update of the row and the
//  result register. The modulo loop sets the rate.
//  After reset a clearing pass over all NUM_BUCKETS (256) rows empties the store;
//  requests wait for it, configuration writes are taken throughout.
//  The result register lets the next request in while a result waits; an item
//  holds in its update step only if the previous result is still not taken.

module hash_set_chained (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [1:0]  req_tuser,   // [1:0] func
   // response
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] hit, [1] changed, [2] full_res, rest zero
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [8:0]  csr_data     // [8:0] bucket_count
);
   import hsc_pkg::*;

   hsc_cmd_type cmd;
   hsc_sts_type sts;
   logic [2:0]  rsp_bits;

   // Configuration must be written only while idle (not enforced here), so always take it.
   assign csr_ready = 1'b1;

   hsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   hsc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_func  (req_tuser),
      .req_value (req_tdata),
      .csr_we    (csr_valid && csr_ready),
      .csr_wdata (csr_data),
      .rsp_bits  (rsp_bits)
   );

   // Pad the three result flags out to a whole byte.
   assign rsp_tdata = {5'b0, rsp_bits};

endmodule

`default_nettype wire

FILE: test/hash_set_chained_checker.sv
// Checker for the chained hash set: watches the request, response and
// configuration channels, predicts each response and compares it.
// Depends on hsc_pkg.
`timescale 1ns / 1ps

module hash_set_chained_checker (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   input  wire logic [31:0]               req_tdata,   // [31:0] value
   input  wire logic [1:0]                req_tuser,   // [1:0] func
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic [7:0]                rsp_tdata,   // [0] hit, [1] changed, [2] full_res
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [hsc_pkg::CFG_W-1:0] csr_data,    // [8:0] bucket_count
   output int                             fail_count,
   output int                             pending_count
);
   import hsc_pkg::*;

   localparam int TOTAL_SLOTS = NUM_BUCKETS * SLOTS_PER_BUCKET;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [VAL_W-1:0]  value;
      logic              hit;
      logic              changed;
      logic              full_res;
   } set_outcome_type;

   logic [VAL_W-1:0] slot_value [TOTAL_SLOTS];
   logic             slot_used  [TOTAL_SLOTS];
   logic [CFG_W-1:0] bucket_reg;
   set_outcome_type  outcome_q [$];
   set_outcome_type  oldest;
   int               mismatches = 0;

   assign fail_count = mismatches;

   task automatic report(input string field, input logic [7:0] got, input logic [7:0] want,
                         input logic [VAL_W-1:0] value);
      $display("%0d ns: %s mismatch, got %0h expected %0h (value %08h)",
               $time, field, got, want, value);
      mismatches++;
   endtask

   // Apply one operation to the shadow store and return what the block must answer.
   function automatic set_outcome_type apply_op(input logic [FUNC_W-1:0] func,
                                                input logic [VAL_W-1:0] v);
      set_outcome_type r;
      int unsigned     buckets;
      int unsigned     base;
      int unsigned     found;
      int unsigned     free_slot;
      bit              have_found;
      bit              have_free;
      r          = '0;
      r.func     = func;
      r.value    = v;
      have_found = 1'b0;
      have_free  = 1'b0;
      found      = 0;
      free_slot  = 0;
      buckets    = 32'(bucket_reg);
      if (buckets == 0) buckets = 1;
      if (buckets > NUM_BUCKETS) buckets = NUM_BUCKETS;
      base = (v % buckets) * SLOTS_PER_BUCKET;
      for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
         if (slot_used[base + i]) begin
            if (!have_found && slot_value[base + i] == v) begin
               have_found = 1'b1;
               found      = base + i;
            end
         end else if (!have_free) begin
            have_free = 1'b1;
            free_slot = base + i;
         end
      end
      case (func)
         OP_INSERT: begin
            if (have_found) begin
               r.hit = 1'b1;
            end else if (have_free) begin
               slot_value[free_slot] = v;
               slot_used[free_slot]  = 1'b1;
               r.changed = 1'b1;
            end else begin
               r.full_res = 1'b1;
            end
         end
         OP_SEARCH: begin
            r.hit = have_found;
         end
         OP_REMOVE: begin
            if (have_found) begin
               slot_used[found] = 1'b0;
               r.hit     = 1'b1;
               r.changed = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_SLOTS; i++) slot_used[i] = 1'b0;
         bucket_reg = BUCKET_COUNT_RESET;
         outcome_q.delete();
      end else begin
         if (csr_valid && csr_ready) bucket_reg = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               report("response with nothing pending", rsp_tdata, 8'h00, '0);
            end else begin
               oldest = outcome_q.pop_front();
               if (rsp_tdata[0] !== oldest.hit)
                  report("hit", 8'(rsp_tdata[0]), 8'(oldest.hit), oldest.value);
               if (rsp_tdata[1] !== oldest.changed)
                  report("changed", 8'(rsp_tdata[1]), 8'(oldest.changed), oldest.value);
               if (rsp_tdata[2] !== oldest.full_res)
                  report("full_res", 8'(rsp_tdata[2]), 8'(oldest.full_res), oldest.value);
               if (rsp_tdata[7:3] !== 5'b0)
                  report("padding", 8'(rsp_tdata[7:3]), 8'h00, oldest.value);
            end
         end
         if (req_tvalid && req_tready) outcome_q.push_back(apply_op(req_tuser, req_tdata));
      end
      pending_count <= outcome_q.size();
   end

endmodule

FILE: test/hash_set_chained_tb.sv
// Testbench top for the chained hash set: drives requests, configuration
// writes and response back-pressure, and gives the verdict.
// Depends on hsc_pkg, hash_set_chained and hash_set_chained_checker.
`timescale 1ns / 1ps

module hash_set_chained_tb;
   import hsc_pkg::*;

   // func code with no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;    // a little above the latency of one item
   localparam int MAX_GAP       = 16;
   localparam int PHASE_ITEMS   = 140;
   localparam int POOL_SIZE     = 16;
   localparam int NUM_PHASES    = 12;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic [31:0]      req_tdata  = '0;
   logic [1:0]       req_tuser  = '0;
   logic             rsp_tready = 1'b0;
   logic             csr_valid  = 1'b0;
   logic [CFG_W-1:0] csr_data   = '0;
   wire logic        req_tready;
   wire logic        rsp_tvalid;
   wire logic [7:0]  rsp_tdata;
   wire logic        csr_ready;

   int               fail_count;
   int               pending_count;
   bit               sender_lazy = 1'b1;
   bit               sink_lazy   = 1'b1;
   int               sink_hold   = 0;
   int               sink_draw;
   logic [VAL_W-1:0] value_pool [POOL_SIZE];

   initial begin
      forever #10 clock = ~clock;
   end

   hash_set_chained uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   hash_set_chained_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Response sink: after a transaction, or now and then while waiting, drop
   // tready for a drawn number of cycles. Raise it again only when the hold runs out,
   // so tready gets one assignment per edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         sink_hold  <= 0;
      end else if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
         if (sink_hold == 1) rsp_tready <= 1'b1;
      end else if (sink_lazy && ((rsp_tvalid && rsp_tready) || $urandom_range(0, 15) == 0)) begin
         sink_draw = $urandom_range(0, MAX_GAP);
         if (sink_draw != 0) begin
            rsp_tready <= 1'b0;
            sink_hold  <= sink_draw;
         end
      end
   end

   // Offer one request transaction after a drawn gap and hold it until taken.
   // With no gap, keep tvalid high straight from the previous transaction.
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [VAL_W-1:0] value);
      int gap;
      gap = sender_lazy ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop offering requests and wait until every predicted response has come;
   // with settle, wait out the latency as well so the block is idle.
   task automatic wait_idle(input bit settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the bucket count, then refill the value pool so that most values
   // crowd into a few buckets of the new mapping and fill them up.
   task automatic new_phase(input logic [CFG_W-1:0] count);
      int unsigned live;
      int unsigned home;
      csr_valid <= 1'b1;
      csr_data  <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      live = (count == 0) ? 1 : ((count > NUM_BUCKETS) ? NUM_BUCKETS : count);
      for (int i = 0; i < POOL_SIZE; i++) begin
         home = $urandom_range(0, (live < 4) ? live - 1 : 3);
         if (i < 12)
            value_pool[i] = home + live * $urandom_range(0, 32'hFFFF_FFF0 / live);
         else
            value_pool[i] = $urandom();
      end
      sender_lazy = ($urandom_range(0, 3) != 0);
      sink_lazy   = ($urandom_range(0, 3) != 0);
      @(posedge clock);
   endtask

   initial begin
      logic [CFG_W-1:0] count;
      logic [FUNC_W-1:0] func;
      logic [VAL_W-1:0] value;
      int               pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset bucket count of 256.
      // Fill bucket 0, overflow it, hit a duplicate, then free its third slot.
      send_item(OP_INSERT, 32'd0);
      send_item(OP_INSERT, 32'd256);
      send_item(OP_INSERT, 32'd512);
      send_item(OP_INSERT, 32'd768);
      send_item(OP_INSERT, 32'd1024);
      send_item(OP_INSERT, 32'd256);
      send_item(OP_SEARCH, 32'd512);
      send_item(OP_REMOVE, 32'd512);
      send_item(OP_SEARCH, 32'd512);
      send_item(OP_REMOVE, 32'd512);
      // lowest free slot is the one just emptied
      send_item(OP_INSERT, 32'd1024);
      send_item(OP_SEARCH, 32'd1024);
      // most negative value lands in the now full bucket 0
      send_item(OP_INSERT, 32'h8000_0000);
      // top bucket, last row of the store
      send_item(OP_INSERT, 32'h7FFF_FFFF);
      send_item(OP_INSERT, 32'hFFFF_FFFF);
      send_item(OP_SEARCH, 32'hFFFF_FFFF);
      send_item(OP_REMOVE, 32'h7FFF_FFFF);
      send_item(FUNC_UNUSED, 32'hFFFF_FFFF);
      send_item(OP_SEARCH, 32'h7FFF_FFFF);
      send_item(OP_REMOVE, 32'hFFFF_FFFF);
      wait_idle(1'b1);

      // Random phases. The store carries over, so each new mapping also
      // meets entries left behind by the previous one.
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       count = 9'd1;
            1:       count = 9'd0;
            2:       count = 9'd511;
            3:       count = 9'd257;
            4:       count = 9'd3;
            5:       count = 9'd7;
            6:       count = 9'd2;
            7:       count = 9'd5;
            8:       count = 9'd16;
            9:       count = 9'd100;
            10:      count = 9'd256;
            default: count = $urandom_range(1, 256);
         endcase
         new_phase(count);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // now and then drain the block completely before going on
            if ($urandom_range(0, 39) == 0) wait_idle(1'b0);
            pick = $urandom_range(0, 19);
            if (pick < 8)       func = OP_INSERT;
            else if (pick < 14) func = OP_SEARCH;
            else if (pick < 19) func = OP_REMOVE;
            else                func = FUNC_UNUSED;
            pick = $urandom_range(0, 19);
            if (pick < 16) begin
               value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (pick < 18) begin
               value = $urandom();
            end else begin
               case ($urandom_range(0, 3))
                  0:       value = 32'h0000_0000;
                  1:       value = 32'hFFFF_FFFF;
                  2:       value = 32'h8000_0000;
                  default: value = 32'h7FFF_FFFF;
               endcase
            end
            send_item(func, value);
         end
         wait_idle(1'b1);
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("** hash_set_chained: PASSED **");
      end else begin
         $display("** hash_set_chained: FAILED **");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("** hash_set_chained: FAILED **");
      $finish;
   end

endmodule

FILE: hash_set_chained.f
hdl/hsc_pkg.sv
hdl/hsc_dp.sv
hdl/hsc_ctrl.sv
hdl/hash_set_chained.sv
test/hash_set_chained_checker.sv
test/hash_set_chained_tb.sv
